// ===== design/iqr_pkg.sv =====
// ----------------------------------------------------------------------------
// iqr_pkg: shared types and constants
// Record layout, queue item, back-end state encoding and result limits.
// ----------------------------------------------------------------------------
package iqr_pkg;

    localparam int MAX_RESULTS = 64;
    localparam int RCW         = $clog2(MAX_RESULTS + 1);

    // configuration register indexes
    localparam logic CFG_START_YEAR = 1'b0;
    localparam logic CFG_END_YEAR   = 1'b1;

    // record, year in the lowest bits
    typedef struct packed {
        logic signed [10:0] temp;
        logic [4:0]         day;
        logic [3:0]         month;
        logic [11:0]        year;
    } t_rec;

    // item passed from front to back
    typedef struct packed {
        t_rec rec;
        logic keep;
        logic fin;
    } t_qitem;

    typedef enum logic [3:0] {
        S_LOAD,
        S_RK_OUT,
        S_RK_OUTW,
        S_RK_IN,
        S_RK_END,
        S_BOUNDS,
        S_SC_RD,
        S_SC_CHK,
        S_FLUSH
    } t_state;

endpackage

// ===== design/iqr_front.sv =====
// ----------------------------------------------------------------------------
// iqr_front: input filter
// Holds the year range registers and tags each record as kept or not.
// ----------------------------------------------------------------------------
module iqr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [11:0]   i_cfg_data,
    input  logic          i_valid,
    input  logic [31:0]   i_data,
    input  logic          i_last,
    output logic          o_ready,
    output logic          o_push,
    output iqr_pkg::t_qitem o_item,
    input  logic          i_full
);
    import iqr_pkg::*;

    logic [11:0] r_start_year;
    logic [11:0] r_end_year;
    t_rec        w_rec;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_year <= 12'd0;
            r_end_year   <= 12'd4095;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_YEAR: r_start_year <= i_cfg_data;
                CFG_END_YEAR:   r_end_year   <= i_cfg_data;
                default:        r_start_year <= r_start_year;
            endcase
        end
    end

    // classify and forward
    assign w_rec       = t_rec'(i_data);
    assign o_ready     = !i_full;
    assign o_push      = i_valid && !i_full;
    assign o_item.rec  = w_rec;
    assign o_item.keep = (w_rec.year >= r_start_year) && (w_rec.year <= r_end_year);
    assign o_item.fin  = i_last;

endmodule

// ===== design/iqr_fifo.sv =====
// ----------------------------------------------------------------------------
// iqr_fifo: short queue between front and back
// Four-entry queue that decouples input stalls from processing.
// ----------------------------------------------------------------------------
module iqr_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  iqr_pkg::t_qitem i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output iqr_pkg::t_qitem o_item
);
    import iqr_pkg::*;

    t_qitem     r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic       w_pop;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_item  = r_mem[r_rp];
    assign w_pop   = i_pop && !o_empty;

    // store entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {2'd0, i_push} - {2'd0, w_pop};
        end
    end

endmodule

// ===== design/iqr_back.sv =====
// ----------------------------------------------------------------------------
// iqr_back: record store, quartile ranking and outlier scan
// Stores kept records, ranks them to find Q1 and Q3, then emits outliers.
// ----------------------------------------------------------------------------
module iqr_back #(
    parameter int DEPTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  iqr_pkg::t_qitem i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_data,
    output logic [1:0]      o_user,
    output logic            o_last
);
    import iqr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_state r_state, n_state;

    t_rec   r_mem [DEPTH];
    t_rec   r_rd_data;
    logic [AW-1:0] w_rd_addr;
    logic   w_wr;

    logic [CW-1:0] r_n, n_n;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_jd;
    logic          r_vld_d;
    logic [CW-1:0] r_rank, n_rank;
    logic signed [10:0] r_vi, n_vi;
    logic signed [10:0] r_q1, n_q1;
    logic signed [10:0] r_q3, n_q3;
    logic signed [15:0] r_lo2, n_lo2;
    logic signed [15:0] r_hi2, n_hi2;
    t_rec          r_pend, n_pend;
    logic          r_pend_vld, n_pend_vld;
    logic [RCW-1:0] r_rcnt, n_rcnt;

    logic          r_out_valid, n_out_valid;
    t_rec          r_out_rec, n_out_rec;
    logic [1:0]    r_out_user, n_out_user;
    logic          r_out_last, n_out_last;

    logic          w_can_emit;
    logic          w_inc;
    logic [CW-1:0] w_rank_full;
    logic [CW-1:0] w_q1_idx;
    logic [CW-1:0] w_q3_idx;
    logic [CW+1:0] w_n3;
    logic signed [11:0] w_iqr;
    logic signed [15:0] w_iqr3;
    logic signed [15:0] w_t2;
    logic          w_outl;

    // quartile positions
    assign w_n3     = {2'b00, r_n} + {1'b0, r_n, 1'b0};
    assign w_q1_idx = r_n >> 2;
    assign w_q3_idx = w_n3[CW+1:2];

    // rank increment for the delayed inner read
    assign w_inc = r_vld_d && (($signed(r_rd_data.temp) < r_vi) ||
                   (($signed(r_rd_data.temp) == r_vi) && (r_jd < r_i)));
    assign w_rank_full = r_rank + {{(CW-1){1'b0}}, w_inc};

    // fence arithmetic on doubled values
    assign w_iqr  = 12'(r_q3) - 12'(r_q1);
    assign w_iqr3 = 16'(w_iqr) + (16'(w_iqr) <<< 1);
    assign w_t2   = 16'($signed(r_rd_data.temp)) <<< 1;
    assign w_outl = (w_t2 < r_lo2) || (w_t2 > r_hi2);

    assign w_can_emit = !r_out_valid || i_ready;
    assign o_pop      = (r_state == S_LOAD) && !i_empty;
    assign w_wr       = o_pop && i_item.keep && (r_n < CW'(DEPTH));

    // memory read address
    always_comb begin
        case (r_state)
            S_RK_IN: w_rd_addr = r_j[AW-1:0];
            default: w_rd_addr = r_i[AW-1:0];
        endcase
    end

    // record memory
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_n[AW-1:0]] <= i_item.rec;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_rank      = r_rank;
        n_vi        = r_vi;
        n_q1        = r_q1;
        n_q3        = r_q3;
        n_lo2       = r_lo2;
        n_hi2       = r_hi2;
        n_pend      = r_pend;
        n_pend_vld  = r_pend_vld;
        n_rcnt      = r_rcnt;
        n_out_valid = r_out_valid && !i_ready;
        n_out_rec   = r_out_rec;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;
        case (r_state)
            S_LOAD: begin
                if (o_pop) begin
                    if (w_wr) begin
                        n_n = r_n + CW'(1);
                    end else if (i_item.keep) begin
                        n_ovf = 1'b1;
                    end
                    if (i_item.fin) begin
                        n_i = '0;
                        if (w_wr || (r_n != '0)) begin
                            n_state = S_RK_OUT;
                        end else begin
                            n_state = S_FLUSH;
                        end
                    end
                end
            end
            S_RK_OUT: begin
                n_state = S_RK_OUTW;
            end
            S_RK_OUTW: begin
                n_vi    = $signed(r_rd_data.temp);
                n_j     = '0;
                n_rank  = '0;
                n_state = S_RK_IN;
            end
            S_RK_IN: begin
                n_rank = w_rank_full;
                n_j    = r_j + CW'(1);
                if (r_j + CW'(1) == r_n) begin
                    n_state = S_RK_END;
                end
            end
            S_RK_END: begin
                if (w_rank_full == w_q1_idx) begin
                    n_q1 = r_vi;
                end
                if (w_rank_full == w_q3_idx) begin
                    n_q3 = r_vi;
                end
                n_i = r_i + CW'(1);
                if (r_i + CW'(1) == r_n) begin
                    n_state = S_BOUNDS;
                end else begin
                    n_state = S_RK_OUT;
                end
            end
            S_BOUNDS: begin
                n_lo2   = (16'(r_q1) <<< 1) - w_iqr3;
                n_hi2   = (16'(r_q3) <<< 1) + w_iqr3;
                n_i     = '0;
                n_state = S_SC_RD;
            end
            S_SC_RD: begin
                n_state = S_SC_CHK;
            end
            S_SC_CHK: begin
                if (w_outl && (r_rcnt < RCW'(MAX_RESULTS))) begin
                    if (!r_pend_vld || w_can_emit) begin
                        if (r_pend_vld) begin
                            n_out_valid = 1'b1;
                            n_out_rec   = r_pend;
                            n_out_user  = {r_ovf, 1'b1};
                            n_out_last  = 1'b0;
                        end
                        n_pend     = r_rd_data;
                        n_pend_vld = 1'b1;
                        n_rcnt     = r_rcnt + RCW'(1);
                        n_i        = r_i + CW'(1);
                        n_state    = (r_i + CW'(1) == r_n) ? S_FLUSH : S_SC_RD;
                    end
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = (r_i + CW'(1) == r_n) ? S_FLUSH : S_SC_RD;
                end
            end
            S_FLUSH: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_rec   = r_pend_vld ? r_pend : t_rec'(32'd0);
                    n_out_user  = {r_ovf, r_pend_vld};
                    n_out_last  = 1'b1;
                    n_pend_vld  = 1'b0;
                    n_rcnt      = '0;
                    n_n         = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // state register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_n         <= '0;
            r_ovf       <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_rcnt      <= '0;
            r_out_valid <= 1'b0;
            r_vld_d     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_ovf       <= n_ovf;
            r_pend_vld  <= n_pend_vld;
            r_rcnt      <= n_rcnt;
            r_out_valid <= n_out_valid;
            r_vld_d     <= (r_state == S_RK_IN);
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_jd       <= r_j;
        r_rank     <= n_rank;
        r_vi       <= n_vi;
        r_q1       <= n_q1;
        r_q3       <= n_q3;
        r_lo2      <= n_lo2;
        r_hi2      <= n_hi2;
        r_pend     <= n_pend;
        r_out_rec  <= n_out_rec;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_rec;
    assign o_user  = r_out_user;
    assign o_last  = r_out_last;

`ifndef ASSERT_OFF
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_n == CW'(DEPTH)))
        else $error("overflow set while store not full");
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= RCW'(MAX_RESULTS))
        else $error("result count above limit");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !o_pop)
        else $error("queue popped while processing");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !r_pend_vld)
        else $error("pending outlier left after run");
`endif

endmodule

// ===== design/iqr_outlier_detector.sv =====
// Records load at one per cycle while loading; after the final record the
// block ranks all n kept records on the single read port, then scans them
// one by one before the last result appears. Runs are processed one at a
// time. Synchronous active-low reset clears control; year range resets to
// 0..4095, the record memory has no clearing pass.
// ----------------------------------------------------------------------------
// iqr_outlier_detector: Tukey-fence outlier detector
// Filters dated temperature records by year and emits IQR outliers.
// ----------------------------------------------------------------------------
module iqr_outlier_detector #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // year[11:0] month[15:12] day[20:16] temperature[31:21]
    input  logic        i_s_axis_tlast,   // final_record
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // out_year out_month out_day out_temperature
    output logic [1:0]  o_m_axis_tuser,   // is_outlier[0] overflowed[1]
    output logic        o_m_axis_tlast    // last_result
);
    import iqr_pkg::*;

    t_qitem w_push_item;
    t_qitem w_pop_item;
    logic   w_push;
    logic   w_full;
    logic   w_empty;
    logic   w_pop;

    iqr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_axis_tvalid),
        .i_data     (i_s_axis_tdata),
        .i_last     (i_s_axis_tlast),
        .o_ready    (o_s_axis_tready),
        .o_push     (w_push),
        .o_item     (w_push_item),
        .i_full     (w_full)
    );

    iqr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_pop_item)
    );

    iqr_back #(.DEPTH(DEPTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_item  (w_pop_item),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_user  (o_m_axis_tuser),
        .o_last  (o_m_axis_tlast)
    );

endmodule

// ===== tb/sv/iqr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqr_checker: outlier prediction and result comparison
// Watches the config port and both stream channels, keeps its own copy of
// the year window and record store, predicts the Tukey-fence outliers of
// each run and compares every output transaction against the oldest one.
// ----------------------------------------------------------------------------
module iqr_checker
    import iqr_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,
    input  logic        i_s_axis_tlast,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [31:0] i_m_axis_tdata,
    input  logic [1:0]  i_m_axis_tuser,
    input  logic        i_m_axis_tlast,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] data;
        logic [1:0]  user;
        logic        last;
    } t_outlier;

    t_outlier outlier_q[$];
    t_rec     kept_recs[DEPTH];
    int       kept_n;
    logic     dropped;
    logic [11:0] win_lo;
    logic [11:0] win_hi;

    assign o_pending = outlier_q.size();

    // Sort the kept temperatures, fence them, queue the outliers in order
    task automatic predict_outliers();
        int srt[DEPTH];
        int v, j, q1, q3, iqr, lo2, hi2, t2, cnt;
        t_outlier item;
        cnt = 0;
        for (int i = 0; i < kept_n; i++) begin
            v = int'(kept_recs[i].temp);
            j = i;
            while (j > 0 && srt[j-1] > v) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        if (kept_n > 0) begin
            q1  = srt[kept_n / 4];
            q3  = srt[(3 * kept_n) / 4];
            iqr = q3 - q1;
            lo2 = 2 * q1 - 3 * iqr;
            hi2 = 2 * q3 + 3 * iqr;
            for (int i = 0; i < kept_n && cnt < MAX_RESULTS; i++) begin
                t2 = 2 * int'(kept_recs[i].temp);
                if (t2 < lo2 || t2 > hi2) begin
                    item.data = kept_recs[i];
                    item.user = {dropped, 1'b1};
                    item.last = 1'b0;
                    outlier_q.insert(outlier_q.size(), item);
                    cnt++;
                end
            end
        end
        if (cnt == 0) begin
            item.data = '0;
            item.user = {dropped, 1'b0};
            item.last = 1'b1;
            outlier_q.insert(outlier_q.size(), item);
        end else begin
            outlier_q[outlier_q.size() - 1].last = 1'b1;
        end
        kept_n  = 0;
        dropped = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_rec rec;
        t_outlier exp_item;
        if (!i_rst_n) begin
            kept_n   = 0;
            dropped  = 1'b0;
            win_lo   = 12'd0;
            win_hi   = 12'd4095;
            o_errors = 0;
            outlier_q.delete();
        end else begin
            // track the year window
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_START_YEAR) win_lo = i_cfg_data;
                else win_hi = i_cfg_data;
            end
            // filter and store each input transaction
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                rec = i_s_axis_tdata;
                if (rec.year >= win_lo && rec.year <= win_hi) begin
                    if (kept_n < DEPTH) begin
                        kept_recs[kept_n] = rec;
                        kept_n = kept_n + 1;
                    end else begin
                        dropped = 1'b1;
                    end
                end
                if (i_s_axis_tlast) predict_outliers();
            end
            // compare each output transaction with the oldest prediction
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (outlier_q.size() == 0) begin
                    o_errors = o_errors + 1;
                    if (o_errors <= 10)
                        $display("unexpected result data=%h user=%b last=%b",
                                 i_m_axis_tdata, i_m_axis_tuser, i_m_axis_tlast);
                end else begin
                    exp_item = outlier_q.pop_front();
                    if (exp_item.data !== i_m_axis_tdata ||
                        exp_item.user !== i_m_axis_tuser ||
                        exp_item.last !== i_m_axis_tlast) begin
                        o_errors = o_errors + 1;
                        if (o_errors <= 10)
                            $display("mismatch: exp data=%h user=%b last=%b, got %h %b %b",
                                     exp_item.data, exp_item.user, exp_item.last,
                                     i_m_axis_tdata, i_m_axis_tuser, i_m_axis_tlast);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: outlier detector testbench
// Drives record runs under several year windows with random gaps and
// output stalls; the checker predicts and compares, this module judges.
// ----------------------------------------------------------------------------
module tb_top;
    import iqr_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [11:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          errors;
    int          pending;
    int          sent;
    logic [11:0] win_lo = 12'd0;
    logic [11:0] win_hi = 12'd4095;
    logic        stall_free = 1'b0;

    always #4 i_clk = ~i_clk;

    iqr_outlier_detector #(.DEPTH(64)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tlast(s_tlast),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser), .o_m_axis_tlast(m_tlast)
    );

    iqr_checker #(.DEPTH(64)) i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(s_tvalid), .i_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tlast(s_tlast),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .i_m_axis_tdata(m_tdata), .i_m_axis_tuser(m_tuser), .i_m_axis_tlast(m_tlast),
        .o_errors(errors), .o_pending(pending)
    );

    // Random gap length: mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Stall the result side in random bursts
    always @(posedge i_clk) begin
        if (stall_free) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 30) == 0) ?
                         ($urandom_range(0, 40) != 0) : 1'b0;
    end

    // Send one record transaction, with an optional gap in front
    task automatic send_rec(input logic [11:0] yr, input logic [3:0] mon,
                            input logic [4:0] dy, input logic [10:0] tmp,
                            input logic fin);
        int gap;
        t_rec rec;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rec.year = yr; rec.month = mon; rec.day = dy; rec.temp = tmp;
        s_tvalid <= 1'b1;
        s_tdata  <= rec;
        s_tlast  <= fin;
        do @(posedge i_clk); while (!s_tready);
        sent++;
    endtask

    // Hold off until every predicted result has been seen
    task automatic drain();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Change the year window while idle
    task automatic set_window(input logic [11:0] lo, input logic [11:0] hi);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_START_YEAR;
        cfg_data <= lo;
        @(posedge i_clk);
        cfg_idx  <= CFG_END_YEAR;
        cfg_data <= hi;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        win_lo = lo;
        win_hi = hi;
    endtask

    // One run of random records around a random center with a few spikes
    task automatic send_run(input int n);
        int center, t, spread;
        logic [11:0] yr;
        logic [3:0]  mon;
        logic [4:0]  dy;
        center = $urandom_range(0, 1200) - 600;
        spread = $urandom_range(2, 80);
        for (int k = 0; k < n; k++) begin
            if (win_lo <= win_hi && $urandom_range(0, 9) != 0)
                yr = 12'($urandom_range(win_lo, win_hi));
            else
                yr = 12'($urandom());
            mon = ($urandom_range(0, 19) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 12));
            dy  = ($urandom_range(0, 19) == 0) ? 5'($urandom()) : 5'($urandom_range(1, 31));
            case ($urandom_range(0, 19))
                0, 1:    t = $urandom_range(0, 2000) - 1000;
                2:       t = $urandom();
                default: t = center + $urandom_range(0, 2 * spread) - spread;
            endcase
            send_rec(yr, mon, dy, 11'(t), k == n - 1);
        end
    endtask

    initial begin
        int n;
        sent = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes of year, month and day, both fences crossed
        send_rec(12'd0,    4'd1,  5'd1,  -11'sd1000, 1'b0);
        send_rec(12'd4095, 4'd12, 5'd31, 11'sd0,     1'b0);
        send_rec(12'd2000, 4'd6,  5'd15, 11'sd1,     1'b0);
        send_rec(12'd2001, 4'd0,  5'd0,  11'sd2,     1'b0);
        send_rec(12'd2002, 4'd15, 5'd31, 11'sd3,     1'b0);
        send_rec(12'd2003, 4'd7,  5'd8,  11'sd4,     1'b0);
        // most negative temperature code
        send_rec(12'd2004, 4'd3,  5'd2,  11'h400,    1'b0);
        send_rec(12'd2005, 4'd9,  5'd9,  11'sd1000,  1'b1);
        // single record: no outlier
        send_rec(12'd1999, 4'd2,  5'd3,  11'sd250,   1'b1);
        // all equal: no outlier
        send_rec(12'd10, 4'd1, 5'd1, 11'sd5, 1'b0);
        send_rec(12'd11, 4'd1, 5'd1, 11'sd5, 1'b0);
        send_rec(12'd12, 4'd1, 5'd1, 11'sd5, 1'b1);
        // start after end: nothing kept
        set_window(12'd2000, 12'd1999);
        send_rec(12'd2000, 4'd5, 5'd5, 11'sd100, 1'b0);
        send_rec(12'd1999, 4'd5, 5'd5, 11'sd900, 1'b1);
        // narrow window at the edges
        set_window(12'd4095, 12'd4095);
        send_rec(12'd4095, 4'd1, 5'd1, 11'sd0,   1'b0);
        send_rec(12'd4094, 4'd1, 5'd1, 11'sd500, 1'b0);
        send_rec(12'd0,    4'd1, 5'd1, 11'sd1,   1'b1);
        set_window(12'd0, 12'd0);
        send_rec(12'd0,    4'd4, 5'd4, 11'sd7,   1'b0);
        send_rec(12'd4095, 4'd4, 5'd4, -11'sd7,  1'b1);

        // random runs under a sequence of windows
        set_window(12'd0, 12'd4095);
        while (sent < 370) begin
            case ($urandom_range(0, 7))
                0: set_window(12'd0, 12'd4095);
                1: set_window(12'($urandom_range(1900, 2000)),
                              12'($urandom_range(2000, 2100)));
                2: set_window(12'($urandom()), 12'($urandom()));
                3: drain();
                default: ;
            endcase
            stall_free <= ($urandom_range(0, 4) == 0);
            n = ($urandom_range(0, 12) == 0) ? $urandom_range(60, 75) : $urandom_range(1, 16);
            send_run(n);
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
